/* rtl/plact_pkg.sv */
// Package: shared types, register indexes and Q16.16 constants of the activation unit.
`timescale 1ns / 1ps
package plact_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned TERM_W = 48;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_MODE      = 2'd0;
	localparam logic [IDX_W-1:0] REG_DIRECTION = 2'd1;
	localparam logic [IDX_W-1:0] REG_KNEE      = 2'd2;

	localparam logic [1:0] MODE_THRESH_RELU = 2'd0;
	localparam logic [1:0] MODE_LEAKY_RELU  = 2'd1;
	localparam logic [1:0] MODE_HARD_SIGM   = 2'd2;

	localparam logic DIR_FORWARD  = 1'b0;
	localparam logic DIR_BACKWARD = 1'b1;

	localparam logic signed [DATA_W-1:0] Q_ONE      = 32'sd65536;
	localparam logic signed [DATA_W-1:0] Q_HALF     = 32'sd32768;
	localparam logic signed [DATA_W-1:0] Q_TWO_HALF = 32'sd163840;
	localparam logic signed [DATA_W-1:0] Q_NEG_TWO_HALF = -32'sd163840;
	localparam logic signed [DATA_W-1:0] FIFTH_Q016 = 32'sd13107;
	localparam logic signed [DATA_W-1:0] Q_ZERO     = 32'sd0;

	localparam logic signed [PROD_W-1:0] RND_POS = 64'sd32768;
	localparam logic signed [PROD_W-1:0] RND_NEG = 64'sd32767;

	localparam logic signed [DATA_W-1:0] Y_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] Y_MIN = 32'sh80000000;

	typedef struct packed {
		logic [1:0]               mode;
		logic                     direction;
		logic signed [DATA_W-1:0] knee_or_slope;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] mul_a;
		logic signed [DATA_W-1:0] mul_b;
		logic                     use_prod;
		logic signed [DATA_W-1:0] pass_val;
		logic signed [DATA_W-1:0] addend;
		logic                     last;
	} dec_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic                     use_prod;
		logic signed [DATA_W-1:0] pass_val;
		logic signed [DATA_W-1:0] addend;
		logic                     last;
	} prod_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] term;
		logic signed [DATA_W-1:0] addend;
		logic                     last;
	} term_t;

endpackage

/* rtl/plact_if.sv */
// Interfaces: input element channel and result channel, valid/ready with payload.
`timescale 1ns / 1ps
interface plact_in_if;
	import plact_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] x;
	logic signed [DATA_W-1:0] grad_in;
	logic signed [DATA_W-1:0] grad_acc;
	logic                     is_last;

	modport source (output valid, output x, output grad_in, output grad_acc, output is_last,
		input ready);
	modport sink (input valid, input x, input grad_in, input grad_acc, input is_last,
		output ready);
endinterface

interface plact_out_if;
	import plact_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] y;
	logic                     saturated;
	logic                     is_last_out;

	modport source (output valid, output y, output saturated, output is_last_out,
		input ready);
	modport sink (input valid, input y, input saturated, input is_last_out,
		output ready);
endinterface

/* rtl/plact_decode.sv */
// Stage 1: compare x against the knees and pick multiplier operands, bypass value and addend.
`timescale 1ns / 1ps
module plact_decode import plact_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     valid_i,
	input  logic signed [DATA_W-1:0] x,
	input  logic signed [DATA_W-1:0] grad_in,
	input  logic signed [DATA_W-1:0] grad_acc,
	input  logic                     is_last,
	output logic                     ready_o,
	output logic                     valid_s1,
	output dec_t                     dec_s1,
	input  logic                     ready_i
);

	dec_t dec_d;
	logic x_gt_knee, x_pos, x_hi, x_lo;

	assign x_gt_knee = x > cfg.knee_or_slope;
	assign x_pos     = x > Q_ZERO;
	assign x_hi      = x > Q_TWO_HALF;
	assign x_lo      = x < Q_NEG_TWO_HALF;

	always_comb begin
		dec_d          = '0;
		dec_d.mul_a    = cfg.knee_or_slope;
		dec_d.mul_b    = x;
		dec_d.last     = is_last;
		if (cfg.direction == DIR_FORWARD) begin
			dec_d.addend = Q_ZERO;
			unique case (cfg.mode)
				MODE_LEAKY_RELU: begin
					dec_d.use_prod = !x_pos;
					dec_d.pass_val = x;
				end
				MODE_HARD_SIGM: begin
					dec_d.mul_a    = FIFTH_Q016;
					dec_d.use_prod = !x_hi && !x_lo;
					dec_d.pass_val = x_hi ? Q_ONE : Q_ZERO;
					dec_d.addend   = (!x_hi && !x_lo) ? Q_HALF : Q_ZERO;
				end
				default: begin
					dec_d.use_prod = 1'b0;
					dec_d.pass_val = x_gt_knee ? x : Q_ZERO;
				end
			endcase
		end else begin
			dec_d.addend = grad_acc;
			dec_d.mul_b  = grad_in;
			unique case (cfg.mode)
				MODE_LEAKY_RELU: begin
					dec_d.use_prod = !x_pos;
					dec_d.pass_val = grad_in;
				end
				MODE_HARD_SIGM: begin
					dec_d.mul_a    = FIFTH_Q016;
					dec_d.use_prod = !x_hi && !x_lo;
					dec_d.pass_val = Q_ZERO;
				end
				default: begin
					dec_d.use_prod = 1'b0;
					dec_d.pass_val = x_gt_knee ? grad_in : Q_ZERO;
				end
			endcase
		end
	end

	assign ready_o = !valid_s1 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

/* rtl/plact_mult.sv */
// Stage 2: exact 32x32 signed product in Q32.32.
`timescale 1ns / 1ps
module plact_mult import plact_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_i,
	input  dec_t  dec_i,
	output logic  ready_o,
	output logic  valid_s2,
	output prod_t prod_s2,
	input  logic  ready_i
);

	logic signed [PROD_W-1:0] prod_d;

	assign prod_d  = PROD_W'(dec_i.mul_a) * PROD_W'(dec_i.mul_b);
	assign ready_o = !valid_s2 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_o) begin
			valid_s2 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			prod_s2.prod     <= prod_d;
			prod_s2.use_prod <= dec_i.use_prod;
			prod_s2.pass_val <= dec_i.pass_val;
			prod_s2.addend   <= dec_i.addend;
			prod_s2.last     <= dec_i.last;
		end
	end

endmodule

/* rtl/plact_round.sv */
// Stage 3: round the product to Q16.16, ties away from zero, and select the term.
`timescale 1ns / 1ps
module plact_round import plact_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_i,
	input  prod_t prod_i,
	output logic  ready_o,
	output logic  valid_s3,
	output term_t term_s3,
	input  logic  ready_i
);

	logic signed [PROD_W-1:0] biased;
	logic signed [TERM_W-1:0] rounded;
	logic signed [TERM_W-1:0] term_d;

	assign biased  = prod_i.prod + (prod_i.prod[PROD_W-1] ? RND_NEG : RND_POS);
	assign rounded = biased[PROD_W-1:FRAC_W];
	assign term_d  = prod_i.use_prod ? rounded : TERM_W'(prod_i.pass_val);
	assign ready_o = !valid_s3 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_o) begin
			valid_s3 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			term_s3.term   <= term_d;
			term_s3.addend <= prod_i.addend;
			term_s3.last   <= prod_i.last;
		end
	end

endmodule

/* rtl/plact_sat.sv */
// Stage 4: add the addend, saturate to Q16.16 and hold the result for transfer.
`timescale 1ns / 1ps
module plact_sat import plact_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_i,
	input  term_t                    term_i,
	output logic                     ready_o,
	output logic                     valid_s4,
	output logic signed [DATA_W-1:0] y_s4,
	output logic                     sat_s4,
	output logic                     last_s4,
	input  logic                     ready_i
);

	localparam int unsigned SUM_W = TERM_W + 1;

	logic signed [SUM_W-1:0]  sum;
	logic signed [DATA_W-1:0] y_d;
	logic                     sat_d;

	assign sum = SUM_W'(term_i.term) + SUM_W'(term_i.addend);

	always_comb begin
		priority if (sum > SUM_W'(Y_MAX)) begin
			y_d   = Y_MAX;
			sat_d = 1'b1;
		end else if (sum < SUM_W'(Y_MIN)) begin
			y_d   = Y_MIN;
			sat_d = 1'b1;
		end else begin
			y_d   = sum[DATA_W-1:0];
			sat_d = 1'b0;
		end
	end

	assign ready_o = !valid_s4 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_o) begin
			valid_s4 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			y_s4    <= y_d;
			sat_s4  <= sat_d;
			last_s4 <= term_i.last;
		end
	end

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && sat_s4 |-> (y_s4 == Y_MAX) || (y_s4 == Y_MIN))
		else $error("saturated result is not at a range limit");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !ready_i |=> valid_s4 && $stable(y_s4) && $stable(sat_s4)
			&& $stable(last_s4))
		else $error("held result changed while stalled");

endmodule

/* rtl/piecewise_linear_activation_core.sv */
// Top level: configuration registers and the four-stage activation pipeline.
`timescale 1ns / 1ps
// Streaming Q16.16 activation unit: thresholded ReLU, leaky ReLU or hard sigmoid in
// forward direction, grad_acc + grad_in * f'(x) in backward direction, with saturation
// and a pass-through last mark. One element is taken every cycle while the result side
// does not stall; each result passes through decode, 32x32 multiply, round, and add and
// saturate, each registered, and a stall at the result side backs the stages up without
// loss. Write the mode, direction and knee/slope registers only while the pipeline is
// empty.
module piecewise_linear_activation_core import plact_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [DATA_W-1:0]  wr_data,
	plact_in_if.sink           elem,
	plact_out_if.source        res
);

	cfg_t  cfg_q;
	logic  valid_s1, valid_s2, valid_s3;
	logic  ready_s1, ready_s2, ready_s3, ready_s4;
	dec_t  dec_s1;
	prod_t prod_s2;
	term_t term_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:      cfg_q.mode          <= wr_data[1:0];
				REG_DIRECTION: cfg_q.direction     <= wr_data[0];
				REG_KNEE:      cfg_q.knee_or_slope <= wr_data;
				default: ;
			endcase
		end
	end

	plact_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_i  (elem.valid),
		.x        (elem.x),
		.grad_in  (elem.grad_in),
		.grad_acc (elem.grad_acc),
		.is_last  (elem.is_last),
		.ready_o  (ready_s1),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.ready_i  (ready_s2)
	);

	plact_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (valid_s1),
		.dec_i    (dec_s1),
		.ready_o  (ready_s2),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2),
		.ready_i  (ready_s3)
	);

	plact_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (valid_s2),
		.prod_i   (prod_s2),
		.ready_o  (ready_s3),
		.valid_s3 (valid_s3),
		.term_s3  (term_s3),
		.ready_i  (ready_s4)
	);

	plact_sat u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (valid_s3),
		.term_i   (term_s3),
		.ready_o  (ready_s4),
		.valid_s4 (res.valid),
		.y_s4     (res.y),
		.sat_s4   (res.saturated),
		.last_s4  (res.is_last_out),
		.ready_i  (res.ready)
	);

	assign elem.ready = ready_s1;

	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!elem.ready |-> res.valid && !res.ready && valid_s1 && valid_s2 && valid_s3)
		else $error("input stalled while pipeline has room");

endmodule
